### rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants for the sphere-sphere contact block.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int BUDGET_BITS = 16;

    typedef logic [BUDGET_BITS-1:0] budget_t;

    localparam budget_t BUDGET_RESET = 16'd256;

    // action codes of an input word
    localparam logic ACT_TEST   = 1'b0;
    localparam logic ACT_RELOAD = 1'b1;

endpackage

### rtl/ssc_csub.sv
// ----------------------------------------------------------------------------
// ssc_csub
// Compare-subtract unit shared by the square root and the divide steps.
// ----------------------------------------------------------------------------
module ssc_csub #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic             ge,
    output logic [WIDTH-1:0] diff
);

    logic [WIDTH:0] wide;

    assign wide = {1'b0, a} - {1'b0, b};
    assign ge   = ~wide[WIDTH];
    assign diff = wide[WIDTH-1:0];

endmodule

### rtl/sphere_sphere_contact.sv
// ----------------------------------------------------------------------------
// sphere_sphere_contact
// Sphere pair contact test: length, unit normal, midpoint and penetration.
// ----------------------------------------------------------------------------
// One word in, one word out. A test word passes through load, squaring and
// the square root steps, then the check; when a contact is found, a divide
// runs for each of the three axes on the one compare-subtract unit before
// the result and idle states. A reload word goes straight to the result
// state. The input is stalled for the whole of a word's work. A finished
// result sits in the output register while the next word is taken in. The
// budget register is written through the cfg channel, which is always ready.
module sphere_sphere_contact #(
    parameter int COORD_BITS = 28,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  ssc_pkg::budget_t               cfg_data,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic signed [COORD_BITS-1:0]   center_one_x,
    input  logic signed [COORD_BITS-1:0]   center_one_y,
    input  logic signed [COORD_BITS-1:0]   center_one_z,
    input  logic        [COORD_BITS-2:0]   radius_one,
    input  logic signed [COORD_BITS-1:0]   center_two_x,
    input  logic signed [COORD_BITS-1:0]   center_two_y,
    input  logic signed [COORD_BITS-1:0]   center_two_z,
    input  logic        [COORD_BITS-2:0]   radius_two,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           hit,
    output logic signed [FRAC_BITS+1:0]    normal_x,
    output logic signed [FRAC_BITS+1:0]    normal_y,
    output logic signed [FRAC_BITS+1:0]    normal_z,
    output logic signed [COORD_BITS-1:0]   point_x,
    output logic signed [COORD_BITS-1:0]   point_y,
    output logic signed [COORD_BITS-1:0]   point_z,
    output logic        [COORD_BITS-1:0]   penetration,
    output ssc_pkg::budget_t               budget_left
);

    localparam int C          = COORD_BITS;
    localparam int RAD_W      = C - 1;
    localparam int NORM_W     = FRAC_BITS + 2;
    localparam int SQ_W       = 2 * C;
    localparam int ACC_W      = 2 * C + 2;
    localparam int ROOT_W     = C + 1;
    localparam int REM_W      = C + 2;
    localparam int UNIT_W     = C + 4;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int ROOT_STEPS = C + 1;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int CNT_W      = $clog2(C + 1);

    localparam logic [CNT_W-1:0] CNT_ROOT_LAST = CNT_W'(ROOT_STEPS - 1);
    localparam logic [CNT_W-1:0] CNT_DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] CNT_SQ_LAST   = CNT_W'(3);
    localparam logic [1:0]       AXIS_X        = 2'd0;
    localparam logic [1:0]       AXIS_Y        = 2'd1;
    localparam logic [1:0]       AXIS_Z        = 2'd2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_SQ    = 3'd2;
    localparam logic [2:0] S_ROOT  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DSET  = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       axis_reg, axis_next;
    logic             out_valid_reg, out_valid_next;
    ssc_pkg::budget_t contacts_reg, contacts_next;
    ssc_pkg::budget_t budget_reg, budget_next;

    // working registers
    logic             action_reg;
    logic [C-1:0]     c1_reg [3];
    logic [C-1:0]     c2_reg [3];
    logic [RAD_W-1:0] r1_reg, r2_reg;
    logic [C-1:0]     mag_reg [3];
    logic             neg_reg [3];
    logic [C-1:0]     mid_reg [3];
    logic [C-1:0]     rsum_reg;
    logic [SQ_W-1:0]  prod_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [NORM_W-1:0] norm_reg [3];
    logic             hit_work_reg;
    logic [C-1:0]     pen_reg;

    // result registers
    logic              res_hit_reg;
    logic [NORM_W-1:0] res_norm_reg [3];
    logic [C-1:0]      res_point_reg [3];
    logic [C-1:0]      res_pen_reg;
    ssc_pkg::budget_t  res_budget_reg;

    logic              in_accept;
    logic              out_free;
    logic [1:0]        sel;
    logic [C-1:0]      mag_sel;
    logic              neg_sel;
    logic [SQ_W-1:0]   prod_c;
    logic [C:0]        dif_c [3];
    logic [C:0]        sum_c [3];
    logic [C-1:0]      abs_c [3];
    logic              hit_c;
    logic [UNIT_W-1:0] unit_a, unit_b, unit_diff;
    logic              unit_ge;
    logic [REM_W-1:0]  rem_step;
    logic [QUO_W-1:0]  quo_step;
    logic [NORM_W-1:0] norm_mag, norm_c;

    assign in_accept = in_valid & ~in_stall;
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // per-axis difference, magnitude and midpoint
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dif_c[k] = {c1_reg[k][C-1], c1_reg[k]} - {c2_reg[k][C-1], c2_reg[k]};
            sum_c[k] = {c1_reg[k][C-1], c1_reg[k]} + {c2_reg[k][C-1], c2_reg[k]};
            abs_c[k] = dif_c[k][C] ? C'(~dif_c[k] + 1'b1) : dif_c[k][C-1:0];
        end
    end

    assign sel = (state_reg == S_SQ) ? cnt_reg[1:0] : axis_reg;

    always_comb
    begin
        case (sel)
            AXIS_X:
            begin
                mag_sel = mag_reg[0];
                neg_sel = neg_reg[0];
            end
            AXIS_Y:
            begin
                mag_sel = mag_reg[1];
                neg_sel = neg_reg[1];
            end
            AXIS_Z:
            begin
                mag_sel = mag_reg[2];
                neg_sel = neg_reg[2];
            end
            default:
            begin
                mag_sel = '0;
                neg_sel = 1'b0;
            end
        endcase
    end

    assign prod_c = mag_sel * mag_sel;

    // root step brings down two radicand bits, divide step one dividend bit
    always_comb
    begin
        if (state_reg == S_ROOT)
        begin
            unit_a = {rem_reg, acc_reg[ACC_W-1 -: 2]};
            unit_b = {1'b0, root_reg, 2'b01};
        end
        else
        begin
            unit_a = {2'b00, rem_reg[ROOT_W-1:0], (cnt_reg == '0) ? mag_sel[0] : 1'b0};
            unit_b = {3'b000, root_reg};
        end
    end

    ssc_csub #(
        .WIDTH (UNIT_W)
    ) u_csub (
        .a    (unit_a),
        .b    (unit_b),
        .ge   (unit_ge),
        .diff (unit_diff)
    );

    assign rem_step = unit_ge ? unit_diff[REM_W-1:0] : unit_a[REM_W-1:0];
    assign quo_step = {quo_reg[QUO_W-2:0], unit_ge};
    assign norm_mag = {1'b0, quo_step};
    assign norm_c   = neg_sel ? NORM_W'(~norm_mag + NORM_W'(1)) : norm_mag;

    assign hit_c = (contacts_reg != '0) && (root_reg != '0)
                   && (root_reg < {1'b0, rsum_reg});

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg;
        contacts_next  = contacts_reg;
        budget_next    = budget_reg;

        if (cfg_valid)
        begin
            budget_next = cfg_data;
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_accept)
                begin
                    state_next = (action == ssc_pkg::ACT_RELOAD) ? S_DONE : S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_SQ;
                cnt_next   = '0;
            end
            S_SQ:
            begin
                if (cnt_reg == CNT_SQ_LAST)
                begin
                    state_next = S_ROOT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ROOT:
            begin
                if (cnt_reg == CNT_ROOT_LAST)
                begin
                    state_next = S_CHECK;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                axis_next  = AXIS_X;
                state_next = hit_c ? S_DSET : S_DONE;
            end
            S_DSET:
            begin
                state_next = S_DIV;
                cnt_next   = '0;
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_DIV_LAST)
                begin
                    cnt_next = '0;
                    if (axis_reg == AXIS_Z)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_DSET;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (action_reg == ssc_pkg::ACT_RELOAD)
                begin
                    contacts_next = budget_reg;
                end
                else if (hit_work_reg)
                begin
                    contacts_next = contacts_reg - 1'b1;
                end
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    contacts_next = contacts_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            axis_reg      <= AXIS_X;
            out_valid_reg <= 1'b0;
            contacts_reg  <= ssc_pkg::BUDGET_RESET;
            budget_reg    <= ssc_pkg::BUDGET_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            contacts_reg  <= contacts_next;
            budget_reg    <= budget_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg   <= action;
            c1_reg[0]    <= center_one_x;
            c1_reg[1]    <= center_one_y;
            c1_reg[2]    <= center_one_z;
            c2_reg[0]    <= center_two_x;
            c2_reg[1]    <= center_two_y;
            c2_reg[2]    <= center_two_z;
            r1_reg       <= radius_one;
            r2_reg       <= radius_two;
            hit_work_reg <= 1'b0;
        end

        case (state_reg)
            S_PREP:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    mag_reg[k] <= abs_c[k];
                    neg_reg[k] <= dif_c[k][C];
                    mid_reg[k] <= sum_c[k][C:1];
                end
                rsum_reg <= {1'b0, r1_reg} + {1'b0, r2_reg};
                acc_reg  <= '0;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            S_SQ:
            begin
                if (cnt_reg != CNT_SQ_LAST)
                begin
                    prod_reg <= prod_c;
                end
                if (cnt_reg != '0)
                begin
                    acc_reg <= acc_reg + {2'b00, prod_reg};
                end
            end
            S_ROOT:
            begin
                rem_reg  <= rem_step;
                root_reg <= {root_reg[ROOT_W-2:0], unit_ge};
                acc_reg  <= {acc_reg[ACC_W-3:0], 2'b00};
            end
            S_CHECK:
            begin
                hit_work_reg <= hit_c;
                pen_reg      <= rsum_reg - root_reg[C-1:0];
            end
            S_DSET:
            begin
                rem_reg <= REM_W'(mag_sel >> 1);
                quo_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
                if (cnt_reg == CNT_DIV_LAST)
                begin
                    norm_reg[axis_reg] <= norm_c;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_hit_reg    <= hit_work_reg;
                    res_pen_reg    <= hit_work_reg ? pen_reg : '0;
                    res_budget_reg <= contacts_next;
                    for (int k = 0; k < 3; k++)
                    begin
                        res_norm_reg[k]  <= hit_work_reg ? norm_reg[k] : '0;
                        res_point_reg[k] <= hit_work_reg ? mid_reg[k] : '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign hit         = res_hit_reg;
    assign normal_x    = $signed(res_norm_reg[0]);
    assign normal_y    = $signed(res_norm_reg[1]);
    assign normal_z    = $signed(res_norm_reg[2]);
    assign point_x     = $signed(res_point_reg[0]);
    assign point_y     = $signed(res_point_reg[1]);
    assign point_z     = $signed(res_point_reg[2]);
    assign penetration = res_pen_reg;
    assign budget_left = res_budget_reg;

endmodule

### rtl/ssc_checker.sv
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks for the sphere-sphere contact block, bound to the top.
// ----------------------------------------------------------------------------
module ssc_checker #(
    parameter int COORD_BITS = 28,
    parameter int FRAC_BITS  = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         hit,
    input logic signed [FRAC_BITS+1:0]  normal_x,
    input logic signed [FRAC_BITS+1:0]  normal_y,
    input logic signed [FRAC_BITS+1:0]  normal_z,
    input logic signed [COORD_BITS-1:0] point_x,
    input logic signed [COORD_BITS-1:0] point_y,
    input logic signed [COORD_BITS-1:0] point_z,
    input logic        [COORD_BITS-1:0] penetration
);

    // a held result word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // the block is busy right after taking a word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again without work cycles");

    // a contact has depth and a nonzero normal
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> penetration != '0
            && (normal_x != '0 || normal_y != '0 || normal_z != '0))
        else $error("contact word without depth or normal");

    // no contact means cleared geometry fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> normal_x == '0 && normal_y == '0 && normal_z == '0
            && point_x == '0 && point_y == '0 && point_z == '0
            && penetration == '0)
        else $error("no-contact word carries geometry");

endmodule

bind sphere_sphere_contact ssc_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_ssc_checker (.*);
